/* design/tws_pkg.sv */
// Shared types and constants for the three-wire serial master.
// Used by every module of the block but the checker; depends on nothing.
package tws_pkg;

    localparam int ADDR_W  = 7;
    localparam int DATA_W  = 8;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 6;
    localparam int SHIFT_W = 16;
    localparam int BIT_W   = 4;

    // Command codes; the unused code behaves as a plain tick.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Phase landmarks within a transaction.
    localparam logic [PHASE_W-1:0] PH_SETUP        = 6'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST_BIT    = 6'd1;
    localparam logic [PHASE_W-1:0] PH_LAST_BIT     = 6'd32;
    localparam logic [PHASE_W-1:0] PH_READ_DATA    = 6'd17;
    localparam logic [PHASE_W-1:0] PH_SAMPLE_FIRST = 6'd18;
    localparam logic [PHASE_W-1:0] PH_LAST         = 6'd34;

    localparam logic [DATA_W-1:0] READ_FLAG = 8'h80;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] wdata;
        logic              sda_in;
    } t_item;

    typedef struct packed {
        logic              csel_n;
        logic              sck;
        logic              sda_out;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rdata;
    } t_result;

endpackage

/* design/tws_in_stage.sv */
// Input register of the three-wire serial master: holds one tick transfer.
// Depends on tws_pkg.
module tws_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tws_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output tws_pkg::t_item o_item
);
    import tws_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Take a new tick when empty or when the held one moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* design/tws_core.sv */
// Transaction state and pin-level logic of the three-wire serial master.
// Depends on tws_pkg.
module tws_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tws_pkg::t_item   i_item,
    output tws_pkg::t_result o_result
);
    import tws_pkg::*;

    logic [PHASE_W-1:0] r_phase,     n_phase;
    logic               r_active,    n_active;
    logic               r_is_read,   n_is_read;
    logic [SHIFT_W-1:0] r_out_shift, n_out_shift;
    logic [DATA_W-1:0]  r_in_shift,  n_in_shift;

    logic               start;
    logic               sample;
    logic [PHASE_W-1:0] phase_m1;
    logic [BIT_W-1:0]   bit_idx;
    logic               in_bits;

    assign start  = (i_item.cmd == CMD_WRITE) || (i_item.cmd == CMD_READ);
    // Sample on the tick that closes a high phase of a read data bit.
    assign sample = r_active && r_is_read && (r_phase >= PH_SAMPLE_FIRST)
                    && (r_phase <= PH_LAST_BIT) && !r_phase[0];

    always_comb begin
        n_phase     = r_phase;
        n_active    = r_active;
        n_is_read   = r_is_read;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        if (!r_active) begin
            if (start) begin
                n_active  = 1'b1;
                n_phase   = PH_SETUP;
                n_is_read = (i_item.cmd == CMD_READ);
                if (i_item.cmd == CMD_READ) begin
                    n_out_shift = {READ_FLAG | {1'b0, i_item.address}, {DATA_W{1'b0}}};
                end else begin
                    n_out_shift = {1'b0, i_item.address, i_item.wdata};
                end
            end
        end else begin
            if (sample) begin
                n_in_shift = {r_in_shift[DATA_W-2:0], i_item.sda_in};
            end
            if (r_phase >= PH_LAST) begin
                n_active = 1'b0;
                n_phase  = PH_SETUP;
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SETUP;
            r_active    <= 1'b0;
            r_is_read   <= 1'b0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_is_read   <= n_is_read;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
        end
    end

    // Bit b occupies phases 1+2b and 2+2b; MSB goes first.
    assign phase_m1 = n_phase - 1'b1;
    assign bit_idx  = ~phase_m1[BIT_W:1];
    assign in_bits  = (n_phase >= PH_FIRST_BIT) && (n_phase <= PH_LAST_BIT);

    always_comb begin
        o_result.csel_n    = 1'b1;
        o_result.sck       = 1'b0;
        o_result.sda_out   = 1'b0;
        o_result.sda_drive = 1'b1;
        o_result.busy_res  = 1'b0;
        o_result.done_res  = 1'b0;
        o_result.rdata     = n_in_shift;
        if (n_active) begin
            o_result.busy_res  = 1'b1;
            o_result.csel_n    = (n_phase == PH_LAST);
            o_result.done_res  = (n_phase == PH_LAST);
            o_result.sda_drive = !(n_is_read && (n_phase >= PH_READ_DATA));
            if (in_bits) begin
                o_result.sck = !n_phase[0];
                if (o_result.sda_drive) begin
                    o_result.sda_out = n_out_shift[bit_idx];
                end
            end
        end
    end

endmodule

/* design/tws_out_stage.sv */
// Result register of the three-wire serial master with its valid flag.
// Depends on tws_pkg.
module tws_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tws_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output tws_pkg::t_result o_result
);
    import tws_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register may refill when empty or when its transfer completes.
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/three_wire_serial_master.sv */
// Top level of the three-wire serial master: input register, transaction
// core and result register. Depends on tws_pkg, tws_in_stage, tws_core, tws_out_stage.
//
//  channel | direction | payload                                   | transfer
//  --------+-----------+-------------------------------------------+-------------------
//  s       | in        | tuser: cmd; tdata: address, wdata, sda_in | tvalid && tready
//  m       | out       | tdata: pin levels, busy, done, rdata      | tvalid && tready
//
// One tick per cycle is taken unless the output stalls; each tick yields exactly one
// result, registered first in the input register and then in the result register.
// A transaction spans 35 ticks: setup, 16 bits of two phases, clock low,
// chip select high with done. Synchronous active-low reset returns to idle
// with an empty pipeline and a cleared read byte. A stall on the output side
// holds the result register and, in the same cycle, the full input register;
// input tready follows output tready combinationally.
module three_wire_serial_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [6:0] address, [14:7] wdata, [15] sda_in
    input  logic [15:0] i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] csel_n, [1] sck, [2] sda_out, [3] sda_drive, [4] busy_res,
    // [5] done_res, [13:6] rdata, [15:14] zero
    output logic [15:0] o_m_tdata
);
    import tws_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result core_result;
    t_result out_result;
    logic    held_valid;
    logic    advance;
    logic    core_en;

    // Unpack the incoming transfer.
    assign in_item.cmd     = i_s_tuser;
    assign in_item.address = i_s_tdata[6:0];
    assign in_item.wdata   = i_s_tdata[14:7];
    assign in_item.sda_in  = i_s_tdata[15];

    tws_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Advance the transaction only when the held tick moves into the result register.
    assign core_en = held_valid && advance;

    tws_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (core_en),
        .i_item   (held_item),
        .o_result (core_result)
    );

    tws_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (held_valid),
        .i_result  (core_result),
        .i_ready   (i_m_tready),
        .o_advance (advance),
        .o_valid   (o_m_tvalid),
        .o_result  (out_result)
    );

    // Pack the result, lowest field first, zero padding on top.
    assign o_m_tdata = {2'b00, out_result.rdata, out_result.done_res,
                        out_result.busy_res, out_result.sda_drive,
                        out_result.sda_out, out_result.sck, out_result.csel_n};

endmodule

/* design/tws_checker.sv */
// Port-level checks for the three-wire serial master, bound to the top level.
// Depends on three_wire_serial_master port names only.
module tws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tready,
    input logic        o_m_tvalid,
    input logic [15:0] o_m_tdata
);

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Done only on the chip-select-high phase of a running transaction.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5] |-> o_m_tdata[4] && o_m_tdata[0] && !o_m_tdata[1])
        else $error("done outside final phase");

    // Clock high only under chip select while busy.
    a_sck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> !o_m_tdata[0] && o_m_tdata[4])
        else $error("clock high outside transaction");

    // Idle pins and released data line levels.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (!o_m_tdata[4] || !o_m_tdata[3]) |->
            !o_m_tdata[2] && (o_m_tdata[4] || (o_m_tdata[0] && o_m_tdata[3])))
        else $error("bad idle or released levels");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata)
);
